FILE: rtl/stbp_pkg.sv
// ============================================================================
// stbp_pkg
// Shared types and constants for the session/path binding table.
// ============================================================================
package stbp_pkg;

    // Default configuration
    localparam int TABLE_SLOTS_DEF      = 16;
    localparam int SESSION_ID_BYTES_DEF = 16;

    // Carry fields are sized for the largest table (256 slots)
    localparam int SLOT_IDX_W = 8;
    localparam int FREED_W    = 9;

    localparam int HANDLE_W = 16;
    localparam int PATH_W   = 8;
    localparam int HALF_W   = 64;

    typedef enum logic [1:0] {
        MODE_REGISTER   = 2'd0,
        MODE_LOOKUP     = 2'd1,
        MODE_UNREGISTER = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Command word broadcast to every cell while a scan runs
    typedef struct packed {
        logic [1:0]          mode;
        logic [HALF_W-1:0]   sess_high;
        logic [HALF_W-1:0]   sess_low;
        logic [PATH_W-1:0]   path;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  done;        // key hit (register re-point or lookup)
        logic                  free_ok;     // a free slot has been seen
        logic [SLOT_IDX_W-1:0] vacant_idx;  // lowest free slot seen
        logic [HANDLE_W-1:0]   found;
        logic [FREED_W-1:0]    freed;       // slots freed by unregister
    } carry_t;

    // Fill request for the lowest free slot, issued after the scan
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] idx;
    } fill_t;

endpackage

FILE: rtl/stbp_cell.sv
// ============================================================================
// stbp_cell
// One table slot: holds the key and handle, acts on the scan token as it
// passes and forwards the token to the next slot.
// ============================================================================
module stbp_cell #(
    parameter int INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  stbp_pkg::cmd_t  cmd,
    input  stbp_pkg::fill_t fill,
    input  stbp_pkg::carry_t carry_in,
    output stbp_pkg::carry_t carry_out
);
    import stbp_pkg::*;

    logic [HALF_W-1:0]   sess_high_reg, sess_high_next;
    logic [HALF_W-1:0]   sess_low_reg,  sess_low_next;
    logic [PATH_W-1:0]   path_reg,      path_next;
    logic [HANDLE_W-1:0] handle_reg,    handle_next;
    carry_t              carry_reg,     carry_next;

    logic live;
    logic hit;

    assign live = (handle_reg != '0);
    assign hit  = live && (path_reg == cmd.path) && (sess_high_reg == cmd.sess_high)
                  && (sess_low_reg == cmd.sess_low);

    always_comb
    begin
        sess_high_next = sess_high_reg;
        sess_low_next  = sess_low_reg;
        path_next      = path_reg;
        handle_next    = handle_reg;
        carry_next     = carry_in;

        if (carry_in.valid)
        begin
            case (cmd.mode)
                MODE_REGISTER:
                begin
                    if (cmd.handle != '0 && !carry_in.done)
                    begin
                        if (!live)
                        begin
                            if (!carry_in.free_ok)
                            begin
                                carry_next.free_ok    = 1'b1;
                                carry_next.vacant_idx = SLOT_IDX_W'(INDEX);
                            end
                        end
                        else if (hit)
                        begin
                            handle_next     = cmd.handle;
                            carry_next.done = 1'b1;
                        end
                    end
                end
                MODE_LOOKUP:
                begin
                    if (cmd.path != '0 && !carry_in.done && hit)
                    begin
                        carry_next.found = handle_reg;
                        carry_next.done  = 1'b1;
                    end
                end
                MODE_UNREGISTER:
                begin
                    if (cmd.handle != '0 && handle_reg == cmd.handle)
                    begin
                        handle_next      = '0;
                        path_next        = '0;
                        sess_high_next   = '0;
                        sess_low_next    = '0;
                        carry_next.freed = carry_in.freed + FREED_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fill.en && fill.idx == SLOT_IDX_W'(INDEX))
        begin
            sess_high_next = cmd.sess_high;
            sess_low_next  = cmd.sess_low;
            path_next      = cmd.path;
            handle_next    = cmd.handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_high_reg <= '0;
            sess_low_reg  <= '0;
            path_reg      <= '0;
            handle_reg    <= '0;
            carry_reg     <= '0;
        end
        else
        begin
            sess_high_reg <= sess_high_next;
            sess_low_reg  <= sess_low_next;
            path_reg      <= path_next;
            handle_reg    <= handle_next;
            carry_reg     <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

FILE: rtl/session_path_binding_table_unit.sv
// ============================================================================
// session_path_binding_table_unit
// Binding table of session id + path id keys to connection handles.
// ============================================================================
// The token enters cell 0 after accept and walks the cell chain one slot per
//   cycle; done is registered once it leaves the last cell.
// Words are taken one at a time: busy stays high while the token is in the
//   chain, and a new start is taken in the cycle of done.
// Results come out on a one-cycle done strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous): all slots free, live count zero, idle.
// ============================================================================
module session_path_binding_table_unit #(
    parameter int TABLE_SLOTS      = stbp_pkg::TABLE_SLOTS_DEF,
    parameter int SESSION_ID_BYTES = stbp_pkg::SESSION_ID_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [63:0] sessid_high,
    input  logic [63:0] sessid_low,
    input  logic [7:0]  path_id,
    input  logic [15:0] handle,
    output logic        done,
    output logic        ok,
    output logic [15:0] found_handle,
    output logic [4:0]  live_count
);
    import stbp_pkg::*;

    // Only the leading key bytes of the session id take part in the key;
    // the rest is masked to zero at accept time.
    localparam int KEY_BYTES = (SESSION_ID_BYTES < 1)  ? 1 :
                               (SESSION_ID_BYTES > 16) ? 16 : SESSION_ID_BYTES;
    localparam logic [HALF_W-1:0] HIGH_MASK =
        (KEY_BYTES >= 8) ? {HALF_W{1'b1}} : ({HALF_W{1'b1}} << (64 - 8 * KEY_BYTES));
    localparam logic [HALF_W-1:0] LOW_MASK =
        (KEY_BYTES <= 8)  ? {HALF_W{1'b0}} :
        (KEY_BYTES >= 16) ? {HALF_W{1'b1}} : ({HALF_W{1'b1}} << (128 - 8 * KEY_BYTES));

    // Live count wide enough to hold TABLE_SLOTS itself
    localparam int LIVE_W = $clog2(TABLE_SLOTS + 1);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg,   cmd_next;
    logic                inject_reg, inject_next;
    logic [LIVE_W-1:0]   live_reg,  live_next;
    logic                done_reg,  done_next;
    logic                ok_reg,    ok_next;
    logic [HANDLE_W-1:0] found_reg, found_next;

    carry_t chain [0:TABLE_SLOTS];
    carry_t last;
    fill_t  fill;
    logic   accept;

    logic [LIVE_W+4:0] live_ext;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Token enters cell 0 in the cycle after accept, all flags clear
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = inject_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++)
        begin : g_cell
            stbp_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd_reg),
                .fill      (fill),
                .carry_in  (chain[gi]),
                .carry_out (chain[gi+1])
            );
        end
    endgenerate

    assign last = chain[TABLE_SLOTS];

    // Register with a new key: claim the lowest free slot once the whole
    // chain has been checked for an existing binding.
    always_comb
    begin
        fill.en  = last.valid && (cmd_reg.mode == MODE_REGISTER) && (cmd_reg.handle != '0)
                   && !last.done && last.free_ok;
        fill.idx = last.vacant_idx;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        inject_next = 1'b0;
        live_next   = live_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        found_next  = found_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.mode      = mode;
                    cmd_next.sess_high = sessid_high & HIGH_MASK;
                    cmd_next.sess_low  = sessid_low & LOW_MASK;
                    cmd_next.path      = path_id;
                    cmd_next.handle    = handle;
                    inject_next        = 1'b1;
                    state_next         = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last.valid)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    found_next = '0;
                    case (cmd_reg.mode)
                        MODE_REGISTER:
                        begin
                            ok_next = last.done || fill.en;
                            if (fill.en)
                            begin
                                live_next = live_reg + LIVE_W'(1);
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            ok_next    = last.done;
                            found_next = last.found;
                        end
                        MODE_UNREGISTER:
                        begin
                            live_next = live_reg - LIVE_W'(last.freed);
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            inject_reg <= 1'b0;
            live_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            live_reg   <= live_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
    end

    // Live count reported modulo 32
    assign live_ext = {5'b0, live_reg};

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign found_handle = found_reg;
    assign live_count   = live_ext[4:0];

endmodule

FILE: bench/session_path_binding_table_unit_tb.sv
// ----------------------------------------------------------------------------
// session_path_binding_table_unit_tb
// Self-checking bench for the session/path binding table.
// Feeds register, lookup, unregister and spare-mode words through the
// start/busy handshake and keeps its own copy of the table. Every done strobe
// is checked field by field against the oldest predicted reply. A directed
// opener covers the corner cases, then a random run over a small key pool
// keeps the table near full so hits, re-points and rejects happen often.
// ----------------------------------------------------------------------------
module session_path_binding_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stbp_pkg::*;

    localparam int SLOTS        = 16;
    localparam int ID_BYTES     = 16;
    localparam int SCAN_CYCLES  = SLOTS + 1;     // start edge to done strobe
    localparam int STALL_LIMIT  = 2000;          // cycles with no handshake
    localparam int RANDOM_WORDS = 1520;
    localparam int TAIL_WORDS   = 200;           // closing stretch, no gaps
    localparam int POOL_KEYS    = 24;            // more keys than slots
    localparam int POOL_HANDLES = 12;

    // Mode 3 is not a defined operation; the block must leave the table alone
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One command word plus driver hints
    typedef struct {
        logic [1:0]  op;
        logic [63:0] sess_hi;
        logic [63:0] sess_lo;
        logic [7:0]  path;
        logic [15:0] hdl;
        bit          drain;      // hold off until every reply is back
        int          idle_odds;  // 0: never pause before this word
    } bind_cmd_t;

    typedef struct {
        logic        ok;
        logic [15:0] found;
        logic [4:0]  live;
    } bind_reply_t;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_REGISTER;
    logic [63:0] sessid_high = '0;
    logic [63:0] sessid_low = '0;
    logic [7:0]  path_id = '0;
    logic [15:0] handle = '0;
    logic        done;
    logic        ok;
    logic [15:0] found_handle;
    logic [4:0]  live_count;

    session_path_binding_table_unit #(
        .TABLE_SLOTS      (SLOTS),
        .SESSION_ID_BYTES (ID_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .sessid_high  (sessid_high),
        .sessid_low   (sessid_low),
        .path_id      (path_id),
        .handle       (handle),
        .done         (done),
        .ok           (ok),
        .found_handle (found_handle),
        .live_count   (live_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    bind_cmd_t   cmd_backlog[$];      // words not yet presented
    bind_reply_t replies_due[$];      // predicted replies, oldest first
    bind_cmd_t   cur_cmd;             // word currently on the pins

    int n_sent = 0;                   // words accepted (driver side)
    int n_seen = 0;                   // done strobes seen (monitor side)
    int n_errors = 0;
    int stall_cycles = 0;

    int gap_left = 0;
    bit gap_any = 1'b0;               // count the gap down even while busy
    bit gap_taken = 1'b0;             // head word already had its pause

    // Shadow table
    logic [63:0] tbl_sess_hi[SLOTS];
    logic [63:0] tbl_sess_lo[SLOTS];
    logic [7:0]  tbl_path[SLOTS];
    logic [15:0] tbl_handle[SLOTS];   // 0 = free slot
    int          tbl_live = 0;

    // Tally for the closing summary
    int n_binds = 0;
    int n_hits = 0;
    int n_full_rejects = 0;
    int n_freed = 0;

    // Random key pool
    logic [63:0] pool_hi[POOL_KEYS];
    logic [63:0] pool_lo[POOL_KEYS];
    logic [7:0]  pool_path[POOL_KEYS];

    // ------------------------------------------------------------------
    // Table predictor: applies one word to the shadow table, returns reply.
    // With 16 id bytes the whole 128-bit session id is key, so no masking.
    // ------------------------------------------------------------------
    function automatic bind_reply_t apply_binding_op(bind_cmd_t c);
        bind_reply_t r;
        int          vacant_idx;
        bit          hit;
        r.ok = 1'b0;
        r.found = '0;
        vacant_idx = -1;
        hit = 1'b0;
        case (c.op)
            MODE_REGISTER:
            begin
                // zero handle is refused outright
                if (c.hdl != '0)
                begin
                    for (int i = 0; i < SLOTS && !hit; i++)
                    begin
                        if (tbl_handle[i] == '0)
                        begin
                            if (vacant_idx < 0)
                                vacant_idx = i;
                        end
                        else if (tbl_path[i] == c.path && tbl_sess_hi[i] == c.sess_hi
                                 && tbl_sess_lo[i] == c.sess_lo)
                        begin
                            tbl_handle[i] = c.hdl;   // re-point existing key
                            hit = 1'b1;
                        end
                    end
                    if (!hit && vacant_idx >= 0)
                    begin
                        tbl_sess_hi[vacant_idx] = c.sess_hi;
                        tbl_sess_lo[vacant_idx] = c.sess_lo;
                        tbl_path[vacant_idx]    = c.path;
                        tbl_handle[vacant_idx]  = c.hdl;
                        tbl_live++;
                        hit = 1'b1;
                    end
                    if (hit)
                        n_binds++;
                    else
                        n_full_rejects++;
                    r.ok = hit;
                end
            end
            MODE_LOOKUP:
            begin
                // primary path never hits
                if (c.path != '0)
                begin
                    for (int i = 0; i < SLOTS && !hit; i++)
                    begin
                        if (tbl_handle[i] != '0 && tbl_path[i] == c.path
                            && tbl_sess_hi[i] == c.sess_hi && tbl_sess_lo[i] == c.sess_lo)
                        begin
                            r.found = tbl_handle[i];
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                        n_hits++;
                    r.ok = hit;
                end
            end
            MODE_UNREGISTER:
            begin
                if (c.hdl != '0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (tbl_handle[i] == c.hdl)
                        begin
                            tbl_handle[i]  = '0;
                            tbl_path[i]    = '0;
                            tbl_sess_hi[i] = '0;
                            tbl_sess_lo[i] = '0;
                            if (tbl_live > 0)
                                tbl_live--;
                            n_freed++;
                        end
                    end
                end
            end
            default:
                ;   // spare mode: report count only
        endcase
        r.live = tbl_live[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        $display("[%0t] MISMATCH reply %0d: %s", $realtime, n_seen, msg);
    endtask

    task automatic add_cmd(logic [1:0] op, logic [63:0] hi, logic [63:0] lo,
                           logic [7:0] path, logic [15:0] hdl, int odds,
                           bit drain = 1'b0);
        bind_cmd_t c;
        c.op = op;
        c.sess_hi = hi;
        c.sess_lo = lo;
        c.path = path;
        c.hdl = hdl;
        c.drain = drain;
        c.idle_odds = odds;
        cmd_backlog.push_back(c);
    endtask

    // Mostly small handles so unregister often frees several slots at once
    function automatic logic [15:0] pick_handle();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 5)
            return 16'h0000;
        else if (roll < 15)
            return 16'($urandom_range(65535, 1));
        else
            return 16'($urandom_range(POOL_HANDLES, 1));
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the backlog head, pauses in random bursts, and
    // honors drain markers. One assignment to start per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        bind_cmd_t nxt;
        logic      fire;
        if (rst_n)
        begin
            fire = start;
            if (start && !busy)
            begin
                replies_due.push_back(apply_binding_op(cur_cmd));
                n_sent++;
                fire = 1'b0;
            end
            if (!fire)
            begin
                if (gap_left > 0)
                begin
                    // some gaps only run down while the block is idle, so
                    // they land between scans instead of hiding inside one
                    if (gap_any || !busy)
                        gap_left--;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    nxt = cmd_backlog[0];
                    if (nxt.drain)
                    begin
                        if (n_sent == n_seen)
                            void'(cmd_backlog.pop_front());
                    end
                    else if (!gap_taken && nxt.idle_odds != 0
                             && $urandom_range(nxt.idle_odds - 1, 0) == 0)
                    begin
                        gap_left  = $urandom_range(16, 1);
                        gap_any   = $urandom_range(1, 0);
                        gap_taken = 1'b1;
                    end
                    else
                    begin
                        void'(cmd_backlog.pop_front());
                        cur_cmd     = nxt;
                        gap_taken   = 1'b0;
                        mode        <= nxt.op;
                        sessid_high <= nxt.sess_hi;
                        sessid_low  <= nxt.sess_lo;
                        path_id     <= nxt.path;
                        handle      <= nxt.hdl;
                        fire        = 1'b1;
                    end
                end
            end
            start <= fire;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each done strobe, runs the stall watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_proc
        bind_reply_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reply ok=%0b found=%h live=%0d",
                                              ok, found_handle, live_count));
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok %b, want %b", ok, want.ok));
                    if (found_handle !== want.found)
                        report_mismatch($sformatf("found_handle %h, want %h",
                                                  found_handle, want.found));
                    if (live_count !== want.live)
                        report_mismatch($sformatf("live_count %0d, want %0d",
                                                  live_count, want.live));
                end
                n_seen <= n_seen + 1;
            end
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $realtime,
                         STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim_proc
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  path;
        int          k;
        int          roll;
        int          odds;

        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_sess_hi[i] = '0;
            tbl_sess_lo[i] = '0;
            tbl_path[i]    = '0;
            tbl_handle[i]  = '0;
        end

        // Key pool: groups of four - a fresh key, the same session on another
        // path, the same session off by one bit, and a key that may use path 0
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            case (i % 4)
                1:
                begin
                    pool_hi[i]   = pool_hi[i-1];
                    pool_lo[i]   = pool_lo[i-1];
                    pool_path[i] = pool_path[i-1] ^ 8'($urandom_range(255, 1));
                end
                2:
                begin
                    k = $urandom_range(127, 0);
                    pool_hi[i]   = pool_hi[i-2];
                    pool_lo[i]   = pool_lo[i-2];
                    pool_path[i] = pool_path[i-2];
                    if (k < 64)
                        pool_lo[i][k] = ~pool_lo[i][k];
                    else
                        pool_hi[i][k-64] = ~pool_hi[i][k-64];
                end
                3:
                begin
                    pool_hi[i]   = {$urandom, $urandom};
                    pool_lo[i]   = {$urandom, $urandom};
                    pool_path[i] = 8'($urandom_range(255, 0));
                end
                default:
                begin
                    pool_hi[i]   = {$urandom, $urandom};
                    pool_lo[i]   = {$urandom, $urandom};
                    pool_path[i] = 8'($urandom_range(255, 1));
                end
            endcase
        end

        // Directed opener
        add_cmd(MODE_LOOKUP, 64'h0, 64'h0, 8'd1, 16'h0000, 3);        // empty table miss
        add_cmd(MODE_REGISTER, 64'h1, 64'h2, 8'd1, 16'h0000, 3);      // zero handle refused
        add_cmd(MODE_REGISTER, 64'h0, 64'h0, 8'd0, 16'hFFFF, 3);      // path 0 binds fine
        add_cmd(MODE_LOOKUP, 64'h0, 64'h0, 8'd0, 16'h0000, 3);        // path 0 never hits
        add_cmd(MODE_REGISTER, '1, '1, 8'hFF, 16'h0001, 3);
        add_cmd(MODE_LOOKUP, '1, '1, 8'hFF, 16'h0000, 3);
        add_cmd(MODE_REGISTER, '1, '1, 8'hFF, 16'h8000, 3);           // re-point, no new slot
        add_cmd(MODE_LOOKUP, '1, '1, 8'hFF, 16'hFFFF, 3);             // handle ignored here
        add_cmd(MODE_UNREGISTER, '1, '1, 8'hFF, 16'h0000, 3);         // zero handle: no-op
        add_cmd(MODE_SPARE, '1, '1, 8'hFF, 16'h8000, 3);
        for (int i = 0; i < SLOTS - 2; i++)                           // fill the table
            add_cmd(MODE_REGISTER, 64'hA5A5_0000_0000_0000 | 64'(i), {$urandom, $urandom},
                    8'(i + 1), 16'h0007, 3);
        add_cmd(MODE_REGISTER, 64'h5A5A_5A5A_5A5A_5A5A, 64'h0, 8'd9, 16'h0003, 3); // full
        add_cmd(MODE_REGISTER, '1, '1, 8'hFF, 16'h0002, 3);           // re-point while full
        add_cmd(MODE_UNREGISTER, 64'h0, 64'h0, 8'd0, 16'h0007, 3);    // frees 14 slots
        add_cmd(MODE_LOOKUP, 64'h0, 64'h0, 8'd0, 16'h0000, 0, 1'b1);  // drain marker

        // Random run in chunks of 100 with varying pause density; the
        // closing stretch has no pauses at all
        odds = 4;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(2, 0))
                    0: odds = 0;
                    1: odds = 8;
                    default: odds = 2;
                endcase
                if (n == 700)
                    add_cmd(MODE_LOOKUP, '0, '0, '0, '0, 0, 1'b1);
            end
            if (n >= RANDOM_WORDS - TAIL_WORDS)
                odds = 0;

            // mostly pool keys, some fresh noise
            k = $urandom_range(POOL_KEYS - 1, 0);
            if ($urandom_range(9, 0) == 0)
            begin
                hi   = {$urandom, $urandom};
                lo   = {$urandom, $urandom};
                path = 8'($urandom_range(255, 0));
            end
            else
            begin
                hi   = pool_hi[k];
                lo   = pool_lo[k];
                path = pool_path[k];
            end

            roll = $urandom_range(99, 0);
            if (roll < 45)
                add_cmd(MODE_REGISTER, hi, lo, path, pick_handle(), odds);
            else if (roll < 83)
            begin
                if ($urandom_range(19, 0) == 0)
                    path = '0;
                add_cmd(MODE_LOOKUP, hi, lo, path, 16'($urandom), odds);
            end
            else if (roll < 95)
                add_cmd(MODE_UNREGISTER, hi, lo, path, pick_handle(), odds);
            else
                add_cmd(MODE_SPARE, hi, lo, path, 16'($urandom), odds);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge to stay clear of the driver's updates
        while (cmd_backlog.size() != 0 || start || n_sent != n_seen)
            @(negedge clk);
        repeat (4 * SCAN_CYCLES) @(negedge clk);

        if (replies_due.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));

        $display("Checked %0d words: %0d binds, %0d lookup hits, %0d full-table rejects,",
                 n_seen, n_binds, n_hits, n_full_rejects);
        $display("  %0d slots freed by unregister, %0d mismatches", n_freed, n_errors);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
